>>> sv/pmst_pkg.sv
// Shared constants, types and controller/datapath interface structs for the
// Prim minimum spanning tree block. No dependencies.
package pmst_pkg;

	localparam int MAX_VERTICES_DEF = 16;
	localparam int WEIGHT_BITS_DEF  = 16;

	localparam int VERTEX_W   = 4;
	localparam int WEIGHT_W   = 16;
	localparam int VCOUNT_W   = 5;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd16;
	localparam logic [VERTEX_W-1:0] START_RESET  = 4'd0;

	typedef enum logic {
		REG_VERTEX_COUNT = 1'b0,
		REG_START_VERTEX = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SETUP = 4'b0010,
		ST_PASS  = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	typedef struct packed {
		logic store;
		logic setup;
		logic pass;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic too_small;
		logic pass_done;
		logic finish;
	} dp_sts_t;

endpackage

>>> sv/pmst_regs.sv
// APB configuration registers: vertex count and start vertex.
// Depends on pmst_pkg.
module pmst_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [pmst_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [pmst_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [pmst_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                 pready,
	output logic [pmst_pkg::VCOUNT_W-1:0]        vertex_count,
	output logic [pmst_pkg::VERTEX_W-1:0]        start_vertex
);

	localparam int DW = pmst_pkg::APB_DATA_W;
	localparam int CW = pmst_pkg::VCOUNT_W;
	localparam int SW = pmst_pkg::VERTEX_W;

	pmst_pkg::reg_idx_t reg_idx;
	logic               wr_en;
	logic [CW-1:0]      vertex_count_q;
	logic [SW-1:0]      start_vertex_q;

	assign reg_idx      = pmst_pkg::reg_idx_t'(paddr[2]);
	assign pready       = 1'b1;
	assign wr_en        = psel & penable & pwrite & pready;
	assign vertex_count = vertex_count_q;
	assign start_vertex = start_vertex_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= pmst_pkg::VCOUNT_RESET;
			start_vertex_q <= pmst_pkg::START_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				pmst_pkg::REG_VERTEX_COUNT: vertex_count_q <= pwdata[CW-1:0];
				pmst_pkg::REG_START_VERTEX: start_vertex_q <= pwdata[SW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			pmst_pkg::REG_VERTEX_COUNT: prdata = DW'(vertex_count_q);
			pmst_pkg::REG_START_VERTEX: prdata = DW'(start_vertex_q);
			default:                    prdata = '0;
		endcase
	end

endmodule

>>> sv/pmst_ctrl.sv
// Sequencing state machine for matrix loading and the Prim passes.
// Depends on pmst_pkg.
module pmst_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                last,
	output logic                busy,
	output pmst_pkg::dp_cmd_t   cmd,
	input  pmst_pkg::dp_sts_t   sts
);

	pmst_pkg::state_t state_q;
	pmst_pkg::state_t state_next;

	assign busy = (state_q != pmst_pkg::ST_IDLE);

	always_comb begin
		cmd        = '0;
		state_next = state_q;
		unique case (state_q)
			pmst_pkg::ST_IDLE: begin
				cmd.store = start;
				if (start && last) begin
					state_next = pmst_pkg::ST_SETUP;
				end
			end
			pmst_pkg::ST_SETUP: begin
				cmd.setup  = 1'b1;
				state_next = sts.too_small ? pmst_pkg::ST_IDLE : pmst_pkg::ST_PASS;
			end
			pmst_pkg::ST_PASS: begin
				cmd.pass = 1'b1;
				if (sts.pass_done) begin
					state_next = pmst_pkg::ST_EMIT;
				end
			end
			pmst_pkg::ST_EMIT: begin
				cmd.emit   = 1'b1;
				state_next = sts.finish ? pmst_pkg::ST_IDLE : pmst_pkg::ST_PASS;
			end
			default: state_next = pmst_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pmst_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

>>> sv/pmst_dp.sv
// Datapath: weight memory, per-vertex best cost and parent, tree membership,
// fused relax-and-minimum pass and the result register. Depends on pmst_pkg.
module pmst_dp #(
	parameter int MAX_VERTICES = pmst_pkg::MAX_VERTICES_DEF,
	parameter int WEIGHT_BITS  = pmst_pkg::WEIGHT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pmst_pkg::dp_cmd_t                 cmd,
	output pmst_pkg::dp_sts_t                 sts,
	input  logic [pmst_pkg::VCOUNT_W-1:0]     vertex_count,
	input  logic [pmst_pkg::VERTEX_W-1:0]     start_vertex,
	input  logic [pmst_pkg::VERTEX_W-1:0]     row,
	input  logic [pmst_pkg::VERTEX_W-1:0]     col,
	input  logic [pmst_pkg::WEIGHT_W-1:0]     weight,
	output logic                              done,
	output logic [pmst_pkg::VERTEX_W-1:0]     parent_vertex,
	output logic [pmst_pkg::VERTEX_W-1:0]     new_vertex,
	output logic [pmst_pkg::WEIGHT_W-1:0]     edge_weight,
	output logic                              disconnected,
	output logic                              last_edge
);

	localparam int VW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int NW    = $clog2(MAX_VERTICES + 1);
	localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
	localparam int AW    = $clog2(DEPTH);
	localparam int OVW   = pmst_pkg::VERTEX_W;
	localparam int OWW   = pmst_pkg::WEIGHT_W;
	localparam logic [WEIGHT_BITS-1:0]  NO_EDGE  = '1;
	localparam logic [MAX_VERTICES-1:0] VERTEX0  = MAX_VERTICES'(1);

	logic [WEIGHT_BITS-1:0]  weight_mem_q [DEPTH];
	logic [WEIGHT_BITS-1:0]  best_cost_q [MAX_VERTICES];
	logic [VW-1:0]           best_parent_q [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] in_tree_q;

	logic [NW-1:0]          n_eff;
	logic [VW-1:0]          s_eff;
	logic                   in_range;
	logic [AW-1:0]          wr_addr;
	logic [AW-1:0]          rd_addr;
	logic                   issue;

	logic [NW-1:0]          n_q;
	logic [NW-1:0]          edges_q;
	logic [NW-1:0]          issue_q;
	logic [NW-1:0]          edges_next;
	logic [VW-1:0]          k_q;
	logic [VW-1:0]          kmin_q;
	logic [WEIGHT_BITS-1:0] minc_q;
	logic                   found_q;
	logic                   init_pass_q;

	logic                   rd_valid_s1;
	logic [VW-1:0]          j_s1;
	logic [WEIGHT_BITS-1:0] rdata_s1;

	logic [WEIGHT_BITS-1:0] cur_cost;
	logic [WEIGHT_BITS-1:0] new_cost;
	logic                   take;
	logic                   cand;
	logic                   edge_last;

	logic                   done_q;
	logic [OVW-1:0]         parent_q;
	logic [OVW-1:0]         new_vertex_q;
	logic [OWW-1:0]         edge_weight_q;
	logic                   disconnected_q;
	logic                   last_edge_q;

	always_comb begin
		n_eff    = (32'(vertex_count) > 32'(MAX_VERTICES)) ? NW'(MAX_VERTICES)
		                                                   : NW'(vertex_count);
		s_eff    = (32'(start_vertex) < 32'(n_eff)) ? VW'(start_vertex) : '0;
		in_range = (32'(row) < 32'(MAX_VERTICES)) && (32'(col) < 32'(MAX_VERTICES));
		wr_addr  = AW'(32'(row) * 32'(MAX_VERTICES) + 32'(col));
		issue    = cmd.pass && (issue_q < n_q);
		rd_addr  = AW'(32'(k_q) * 32'(MAX_VERTICES) + 32'(issue_q[VW-1:0]));

		cur_cost = best_cost_q[j_s1];
		take     = init_pass_q || (!in_tree_q[j_s1] && (rdata_s1 < cur_cost));
		new_cost = take ? rdata_s1 : cur_cost;
		cand     = rd_valid_s1 && !in_tree_q[j_s1] && (new_cost < minc_q);

		edges_next = edges_q + NW'(1);
		edge_last  = (edges_next == (n_q - NW'(1)));

		sts.too_small = (n_eff < NW'(2));
		sts.pass_done = rd_valid_s1 && (NW'(j_s1) == (n_q - NW'(1)));
		sts.finish    = !found_q || edge_last;
	end

	always_ff @(posedge clk) begin
		if (cmd.store && in_range) begin
			weight_mem_q[wr_addr] <= WEIGHT_BITS'(weight);
		end
		rdata_s1 <= weight_mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_tree_q   <= '0;
			edges_q     <= '0;
			issue_q     <= '0;
			found_q     <= 1'b0;
			init_pass_q <= 1'b0;
			rd_valid_s1 <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q      <= cmd.emit;
			rd_valid_s1 <= issue;
			if (cmd.setup) begin
				in_tree_q   <= VERTEX0 << s_eff;
				edges_q     <= '0;
				issue_q     <= '0;
				found_q     <= 1'b0;
				init_pass_q <= 1'b1;
			end else if (cmd.emit) begin
				issue_q     <= '0;
				found_q     <= 1'b0;
				init_pass_q <= 1'b0;
				edges_q     <= edges_next;
				if (found_q) begin
					in_tree_q[kmin_q] <= 1'b1;
				end
			end else begin
				if (issue) begin
					issue_q <= issue_q + NW'(1);
				end
				if (cand) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		j_s1 <= issue_q[VW-1:0];
		if (rd_valid_s1 && take) begin
			best_cost_q[j_s1]   <= rdata_s1;
			best_parent_q[j_s1] <= k_q;
		end
		if (cmd.setup) begin
			n_q    <= n_eff;
			k_q    <= s_eff;
			minc_q <= NO_EDGE;
		end else if (cmd.emit) begin
			k_q    <= kmin_q;
			minc_q <= NO_EDGE;
		end else if (cand) begin
			minc_q <= new_cost;
			kmin_q <= j_s1;
		end
		if (cmd.emit) begin
			parent_q       <= found_q ? OVW'(best_parent_q[kmin_q]) : '0;
			new_vertex_q   <= found_q ? OVW'(kmin_q) : '0;
			edge_weight_q  <= found_q ? OWW'(minc_q) : '0;
			disconnected_q <= !found_q;
			last_edge_q    <= !found_q || edge_last;
		end
	end

	assign done          = done_q;
	assign parent_vertex = parent_q;
	assign new_vertex    = new_vertex_q;
	assign edge_weight   = edge_weight_q;
	assign disconnected  = disconnected_q;
	assign last_edge     = last_edge_q;

endmodule

>>> sv/prim_minimum_spanning_tree.sv
// Matrix entries are accepted one per cycle while busy is low. After the last
// entry, with n vertices in use, each edge is found by a pass of n reads
// through the single read port of the weight memory. Results are one
// cycle strobes on done. Reset clears configuration and control state only;
// the weight memory keeps no reset and needs no clearing pass.
module prim_minimum_spanning_tree #(
	parameter int MAX_VERTICES = pmst_pkg::MAX_VERTICES_DEF,
	parameter int WEIGHT_BITS  = pmst_pkg::WEIGHT_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [pmst_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [pmst_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [pmst_pkg::APB_DATA_W-1:0]    prdata,
	output logic                               pready,
	input  logic                               start,
	output logic                               busy,
	input  logic [pmst_pkg::VERTEX_W-1:0]      row,
	input  logic [pmst_pkg::VERTEX_W-1:0]      col,
	input  logic [pmst_pkg::WEIGHT_W-1:0]      weight,
	input  logic                               last,
	output logic                               done,
	output logic [pmst_pkg::VERTEX_W-1:0]      parent_vertex,
	output logic [pmst_pkg::VERTEX_W-1:0]      new_vertex,
	output logic [pmst_pkg::WEIGHT_W-1:0]      edge_weight,
	output logic                               disconnected,
	output logic                               last_edge
);

	logic [pmst_pkg::VCOUNT_W-1:0] vertex_count;
	logic [pmst_pkg::VERTEX_W-1:0] start_vertex;
	pmst_pkg::dp_cmd_t             cmd;
	pmst_pkg::dp_sts_t             sts;

	pmst_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.vertex_count (vertex_count),
		.start_vertex (start_vertex)
	);

	pmst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.last   (last),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	pmst_dp #(
		.MAX_VERTICES (MAX_VERTICES),
		.WEIGHT_BITS  (WEIGHT_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.vertex_count  (vertex_count),
		.start_vertex  (start_vertex),
		.row           (row),
		.col           (col),
		.weight        (weight),
		.done          (done),
		.parent_vertex (parent_vertex),
		.new_vertex    (new_vertex),
		.edge_weight   (edge_weight),
		.disconnected  (disconnected),
		.last_edge     (last_edge)
	);

endmodule
